/* hw/rtl/fifo_page_replacement_defines.svh */
// Assertion macros for the RTL files of the page replacement block.
`ifndef FIFO_PAGE_REPLACEMENT_DEFINES_SVH
`define FIFO_PAGE_REPLACEMENT_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPR_ASSERT_IMPLY(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("fpr assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define FPR_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("fpr assertion failed");

`endif

/* hw/rtl/fpr_pkg.sv */
`timescale 1ns / 1ps

package fpr_pkg;

    // Frame store geometry.
    localparam int FRAMES  = 16;
    localparam int FRAME_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
    localparam int CNT_W   = FRAME_W + 1;
    localparam int PAGE_W  = 32;
    localparam int ADDR_W  = 32;
    localparam int CFG_W   = 5;
    localparam int CNT32_W = 32;

    localparam logic [CNT32_W-1:0] FAULT_MAX = '1;

    // Configuration register indexes.
    localparam logic CFG_OFFSET_BITS   = 1'b0;
    localparam logic CFG_FRAMES_IN_USE = 1'b1;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] OFFSET_RST = CFG_W'(12);
    localparam logic [CFG_W-1:0] FRAMES_RST = CFG_W'(16);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic exec;
    } t_ctrl_cmd;

    // Clamp the programmed frame count into 1..FRAMES.
    function automatic logic [CNT_W-1:0] eff_frames(input logic [CFG_W-1:0] f);
        logic [CNT_W-1:0] n;
        n = '0;
        if (f == '0) begin
            n = CNT_W'(1);
        end else if (32'(f) > FRAMES) begin
            n = CNT_W'(FRAMES);
        end else begin
            n = CNT_W'(f);
        end
        return n;
    endfunction

endpackage

/* hw/rtl/fpr_ctrl.sv */
`timescale 1ns / 1ps

`include "fifo_page_replacement_defines.svh"

module fpr_ctrl
    import fpr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_ctrl_cmd o_cmd
);

    localparam logic S_IDLE = 1'b0;
    localparam logic S_LOOK = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    logic w_slot_free;

    // The result slot is free when empty or when its beat leaves this cycle.
    assign w_slot_free = !r_out_valid || i_out_ready;

    // Next state and commands.
    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_LOOK;
                end
            end
            S_LOOK: begin
                if (w_slot_free) begin
                    o_cmd.exec = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Output valid flag.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    // An accepted beat always leads into the lookup cycle.
    `FPR_ASSERT_NEXT(a_accept_look, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_LOOK)
    // A lookup always leaves a result waiting.
    `FPR_ASSERT_NEXT(a_exec_result, i_clk, i_rst_n, o_cmd.exec, r_out_valid)
    // A stalled result is never dropped.
    `FPR_ASSERT_NEXT(a_hold_result, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)
    // No new item is taken while one is being looked up.
    `FPR_ASSERT_IMPLY(a_no_overlap, i_clk, i_rst_n, r_state == S_LOOK, !o_cmd.capture)

endmodule

/* hw/rtl/fpr_dp.sv */
`timescale 1ns / 1ps

module fpr_dp
    import fpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  t_ctrl_cmd            i_cmd,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic [ADDR_W-1:0]    i_virt_addr,
    input  logic                 i_new_run,
    output logic                 o_fault,
    output logic [FRAME_W-1:0]   o_frame_index,
    output logic [CNT32_W-1:0]   o_fault_count
);

    logic [CFG_W-1:0]   r_offset;
    logic [CFG_W-1:0]   r_frames;
    logic [PAGE_W-1:0]  r_page;
    logic               r_new_run;
    logic [PAGE_W-1:0]  r_frame_page [FRAMES];
    logic [FRAMES-1:0]  r_frame_valid;
    logic [FRAME_W-1:0] r_ptr;
    logic [CNT32_W-1:0] r_count;
    logic               r_fault;
    logic [FRAME_W-1:0] r_frame_index;
    logic [CNT32_W-1:0] r_fault_count;

    logic [CNT_W-1:0]   w_n;
    logic [FRAMES-1:0]  w_valid_eff;
    logic [FRAME_W-1:0] w_ptr_eff;
    logic [CNT32_W-1:0] w_count_eff;
    logic               w_hit;
    logic [FRAME_W-1:0] w_hit_idx;
    logic [FRAME_W-1:0] w_victim;
    logic [CNT_W-1:0]   w_victim_inc;
    logic [FRAME_W-1:0] w_next_ptr;
    logic [FRAME_W-1:0] w_slot;
    logic [CNT32_W-1:0] w_count_new;
    logic [FRAMES-1:0]  w_valid_new;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset <= OFFSET_RST;
            r_frames <= FRAMES_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_OFFSET_BITS:   r_offset <= i_cfg_data;
                CFG_FRAMES_IN_USE: r_frames <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Capture the page number of the accepted beat.
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_page    <= PAGE_W'(i_virt_addr >> r_offset);
            r_new_run <= i_new_run;
        end
    end

    // A new run sees an empty store, pointer zero and count zero.
    assign w_n         = eff_frames(r_frames);
    assign w_valid_eff = r_new_run ? '0 : r_frame_valid;
    assign w_ptr_eff   = r_new_run ? '0 : r_ptr;
    assign w_count_eff = r_new_run ? '0 : r_count;

    // Parallel tag compare; the lowest matching frame wins.
    always_comb begin
        w_hit     = 1'b0;
        w_hit_idx = '0;
        for (int i = FRAMES - 1; i >= 0; i--) begin
            if ((CNT_W'(i) < w_n) && w_valid_eff[i] && (r_frame_page[i] == r_page)) begin
                w_hit     = 1'b1;
                w_hit_idx = FRAME_W'(i);
            end
        end
    end

    // Victim choice and pointer advance; a stale pointer falls back to frame zero.
    assign w_victim     = ({1'b0, w_ptr_eff} < w_n) ? w_ptr_eff : '0;
    assign w_victim_inc = {1'b0, w_victim} + CNT_W'(1);
    assign w_next_ptr   = (w_victim_inc >= w_n) ? '0 : w_victim_inc[FRAME_W-1:0];
    assign w_slot       = w_hit ? w_hit_idx : w_victim;

    // Saturating fault count.
    always_comb begin
        w_count_new = w_count_eff;
        if (!w_hit && (w_count_eff != FAULT_MAX)) begin
            w_count_new = w_count_eff + CNT32_W'(1);
        end
    end

    always_comb begin
        w_valid_new = w_valid_eff;
        if (!w_hit) begin
            w_valid_new[w_victim] = 1'b1;
        end
    end

    // Control state of the store.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_valid <= '0;
            r_ptr         <= '0;
            r_count       <= '0;
        end else if (i_cmd.exec) begin
            r_frame_valid <= w_valid_new;
            r_ptr         <= w_hit ? w_ptr_eff : w_next_ptr;
            r_count       <= w_count_new;
        end
    end

    // Page tags, written on a fault.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec && !w_hit) begin
            r_frame_page[w_victim] <= r_page;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (i_cmd.exec) begin
            r_fault       <= !w_hit;
            r_frame_index <= w_slot;
            r_fault_count <= w_count_new;
        end
    end

    assign o_fault       = r_fault;
    assign o_frame_index = r_frame_index;
    assign o_fault_count = r_fault_count;

endmodule

/* hw/rtl/fifo_page_replacement.sv */
`timescale 1ns / 1ps

// FIFO page replacement: a fully associative store of page frames.
// Input channel (i_in_valid / o_in_ready) carries one access per beat:
// a virtual address and a new_run flag that empties the store first.
// Output channel (o_out_valid / i_out_ready) returns one beat per access:
// hit or fault, the frame holding the page and the saturating fault count.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data):
// index 0 sets the page offset bits, index 1 the number of frames in use.
// Each access has a capture cycle that shifts out the page number, then
// a lookup cycle that compares all frames in parallel, updates the store
// and registers the result; no new access is accepted during the lookup.
// The result sits in an output register, so the next access is accepted
// while it waits. If the receiver stalls, the lookup cycle holds until the
// output register is free, and the input side then stalls too.
// Reset empties all frames, clears the pointer and the fault count and
// loads 12 offset bits and 16 frames; no clearing pass is needed.
module fifo_page_replacement
    import fpr_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic                 i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [ADDR_W-1:0]    i_virt_addr,
    input  logic                 i_new_run,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_fault,
    output logic [FRAME_W-1:0]   o_frame_index,
    output logic [CNT32_W-1:0]   o_fault_count
);

    t_ctrl_cmd w_cmd;

    // Sequencer.
    fpr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // Frame store, lookup and counters.
    fpr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_virt_addr   (i_virt_addr),
        .i_new_run     (i_new_run),
        .o_fault       (o_fault),
        .o_frame_index (o_frame_index),
        .o_fault_count (o_fault_count)
    );

endmodule
